// ===== src/smtlb_pkg.sv =====
// ----------------------------------------------------------------------------
// smtlb_pkg
// shared types, field widths and command / result codes of the translation
// buffer
// ----------------------------------------------------------------------------
`default_nettype none

package smtlb_pkg;

	localparam int ENTRIES_DEF = 16;

	localparam int CMD_W   = 3;
	localparam int SLOT_W  = 6;
	localparam int PAGE_W  = 32;
	localparam int FRAME_W = 48;
	localparam int ACC_W   = 3;
	localparam int KIND_W  = 3;

	// protection bit that makes a slot dirty-capable
	localparam int ACC_WRITE_BIT = 1;

	// command codes
	localparam logic [CMD_W-1:0] CMD_MAP   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PROBE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_UNMAP = 3'd3;
	localparam logic [CMD_W-1:0] CMD_FLUSH = 3'd4;
	localparam logic [CMD_W-1:0] CMD_SYNC  = 3'd5;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_DONE      = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SLOT      = 3'd1;
	localparam logic [KIND_W-1:0] KIND_PROBE     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_WRITEBACK = 3'd3;
	localparam logic [KIND_W-1:0] KIND_BAD_INDEX = 3'd4;

	typedef struct packed {
		logic [PAGE_W-1:0]  page;
		logic [FRAME_W-1:0] frame;
		logic [ACC_W-1:0]   access;
	} entry_t;

	// requests from the sequencer to the slot store
	typedef struct packed {
		logic              rd_en;
		logic [SLOT_W-1:0] rd_addr;
		logic              wr_en;
		logic [SLOT_W-1:0] wr_addr;
		entry_t            wr_data;
		logic              clr_en;
		logic [SLOT_W-1:0] clr_addr;
	} store_req_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic               hit;
		logic [SLOT_W-1:0]  slot;
		logic [PAGE_W-1:0]  page;
		logic [FRAME_W-1:0] frame;
		logic [ACC_W-1:0]   access;
		logic               last;
	} result_t;

endpackage

`default_nettype wire

// ===== src/software_managed_tlb.sv =====
// ----------------------------------------------------------------------------
// software_managed_tlb
// fully associative, software managed translation buffer with write-back
// requests for dirty-capable slots
// ----------------------------------------------------------------------------
// One command word is taken at a time; the next is accepted once the last
// result word of the current command has moved into the output register.
// The slots live in a single-port-read, single-port-write memory with a
// registered read; a command that reads slots issues its first read as it is
// accepted. Read slot answers from that read, map writes the new contents
// and then writes the old ones back if they were valid and writable, probe
// walks the slots up to the first match and unmap, flush and sync walk all
// slots, one per cycle through the read port while no write-back word waits
// on a stalled output side. Bad indexes and unknown codes read no slot.
// The store is empty right after reset without a clearing pass: each slot
// has a written bit that reset clears. Result words per command: write-back
// requests in ascending slot order, then one done word for map, unmap, flush,
// sync and unknown codes; read, probe and bad-index maps give exactly one word.
// ----------------------------------------------------------------------------
`default_nettype none

module software_managed_tlb #(
	parameter int ENTRIES = smtlb_pkg::ENTRIES_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	// command side
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// slot[5:0], page[37:6], frame_addr[85:38], access[88:86], zero pad
	input  wire  [95:0] s_axis_tdata,
	// cmd[2:0]
	input  wire  [2:0]  s_axis_tuser,
	// result side
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// hit[0], slot_out[6:1], page_out[38:7], frame_out[86:39],
	// access_out[89:87], zero pad
	output logic [95:0] m_axis_tdata,
	// kind[2:0]
	output logic [2:0]  m_axis_tuser,
	// last result word of the command
	output logic        m_axis_tlast
);

	smtlb_pkg::store_req_t store_req;
	smtlb_pkg::entry_t     rdata;
	smtlb_pkg::result_t    push_res;
	smtlb_pkg::result_t    out_res;
	logic                  push_valid;
	logic                  push_ready;

	// command word unpacking
	logic [smtlb_pkg::SLOT_W-1:0]  in_slot;
	logic [smtlb_pkg::PAGE_W-1:0]  in_page;
	logic [smtlb_pkg::FRAME_W-1:0] in_frame;
	logic [smtlb_pkg::ACC_W-1:0]   in_access;

	assign in_slot   = s_axis_tdata[5:0];
	assign in_page   = s_axis_tdata[37:6];
	assign in_frame  = s_axis_tdata[85:38];
	assign in_access = s_axis_tdata[88:86];

	smtlb_store #(
		.ENTRIES(ENTRIES)
	) u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (store_req),
		.rdata (rdata)
	);

	smtlb_ctrl #(
		.ENTRIES(ENTRIES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cmd    (s_axis_tuser),
		.in_slot   (in_slot),
		.in_page   (in_page),
		.in_frame  (in_frame),
		.in_access (in_access),
		.store_req (store_req),
		.rdata     (rdata),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_res  (push_res)
	);

	smtlb_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_res  (push_res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	// result word packing, lowest field first
	assign m_axis_tdata = {6'd0, out_res.access, out_res.frame, out_res.page,
		out_res.slot, out_res.hit};
	assign m_axis_tuser = out_res.kind;
	assign m_axis_tlast = out_res.last;

endmodule

`default_nettype wire

// ===== src/smtlb_store.sv =====
// ----------------------------------------------------------------------------
// smtlb_store
// slot memory with one write and one registered read port, plus a
// per-slot written bit so that cleared or never written slots read as zero
// ----------------------------------------------------------------------------
`default_nettype none

module smtlb_store #(
	parameter int ENTRIES = smtlb_pkg::ENTRIES_DEF
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  smtlb_pkg::store_req_t   req,
	output smtlb_pkg::entry_t       rdata
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	smtlb_pkg::entry_t mem [ENTRIES];
	smtlb_pkg::entry_t rd_data_q;
	logic              rd_valid_q;
	logic [ENTRIES-1:0] written_q;

	logic [IW-1:0] rd_idx;
	logic [IW-1:0] wr_idx;
	logic [IW-1:0] clr_idx;

	assign rd_idx  = req.rd_addr[IW-1:0];
	assign wr_idx  = req.wr_addr[IW-1:0];
	assign clr_idx = req.clr_addr[IW-1:0];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[wr_idx] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q  <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.clr_en) begin
				written_q[clr_idx] <= 1'b0;
			end
			if (req.wr_en) begin
				written_q[wr_idx] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_q <= written_q[rd_idx];
			end
		end
	end

	assign rdata = rd_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

// ===== src/smtlb_ctrl.sv =====
// ----------------------------------------------------------------------------
// smtlb_ctrl
// command sequencer: reads slots from the store, decides, writes back and
// emits result words one at a time
// ----------------------------------------------------------------------------
`default_nettype none

module smtlb_ctrl #(
	parameter int ENTRIES = smtlb_pkg::ENTRIES_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire  [smtlb_pkg::CMD_W-1:0]         in_cmd,
	input  wire  [smtlb_pkg::SLOT_W-1:0]        in_slot,
	input  wire  [smtlb_pkg::PAGE_W-1:0]        in_page,
	input  wire  [smtlb_pkg::FRAME_W-1:0]       in_frame,
	input  wire  [smtlb_pkg::ACC_W-1:0]         in_access,
	output smtlb_pkg::store_req_t               store_req,
	input  smtlb_pkg::entry_t                   rdata,
	output logic                                push_valid,
	input  wire                                 push_ready,
	output smtlb_pkg::result_t                  push_res
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MAP_CHK,
		ST_MAP_WB,
		ST_WALK,
		ST_DONE,
		ST_ERR
	} state_t;

	state_t state_q, state_d;

	logic [smtlb_pkg::CMD_W-1:0]   cmd_q;
	logic [smtlb_pkg::SLOT_W-1:0]  slot_q;
	logic [smtlb_pkg::PAGE_W-1:0]  page_q;
	logic [smtlb_pkg::FRAME_W-1:0] frame_q;
	logic [smtlb_pkg::ACC_W-1:0]   acc_q;
	logic [IW-1:0]                 idx_q, idx_d;

	logic slot_ok;
	logic r_valid;
	logic r_match;
	logic r_writable;
	logic idx_last;
	logic walk_wb;
	logic walk_clr;

	assign slot_ok    = in_slot < smtlb_pkg::SLOT_W'(ENTRIES);
	assign r_valid    = rdata.frame != '0;
	assign r_match    = rdata.page == page_q;
	assign r_writable = rdata.access[smtlb_pkg::ACC_WRITE_BIT];
	assign idx_last   = idx_q == IW'(ENTRIES - 1);

	// walk decisions for the slot currently on the read port
	assign walk_wb  = r_valid && r_writable && (cmd_q != smtlb_pkg::CMD_PROBE)
		&& ((cmd_q != smtlb_pkg::CMD_UNMAP) || r_match);
	assign walk_clr = r_valid && (((cmd_q == smtlb_pkg::CMD_UNMAP) && r_match)
		|| (cmd_q == smtlb_pkg::CMD_FLUSH));

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		in_ready   = 1'b0;
		store_req  = '0;
		push_valid = 1'b0;
		push_res   = '0;

		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (in_cmd)
						smtlb_pkg::CMD_MAP,
						smtlb_pkg::CMD_READ: begin
							if (!slot_ok) begin
								state_d = ST_ERR;
							end else begin
								store_req.rd_en   = 1'b1;
								store_req.rd_addr = in_slot;
								state_d = (in_cmd == smtlb_pkg::CMD_MAP) ? ST_MAP_CHK : ST_READ;
							end
						end
						smtlb_pkg::CMD_PROBE,
						smtlb_pkg::CMD_UNMAP,
						smtlb_pkg::CMD_FLUSH,
						smtlb_pkg::CMD_SYNC: begin
							store_req.rd_en   = 1'b1;
							store_req.rd_addr = '0;
							idx_d   = '0;
							state_d = ST_WALK;
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end

			ST_READ: begin
				push_valid      = 1'b1;
				push_res.kind   = smtlb_pkg::KIND_SLOT;
				push_res.slot   = slot_q;
				push_res.page   = rdata.page;
				push_res.frame  = rdata.frame;
				push_res.access = rdata.access;
				push_res.last   = 1'b1;
				if (push_ready) begin
					state_d = ST_IDLE;
				end
			end

			ST_MAP_CHK: begin
				// read data stays on the port: no further read is issued
				store_req.wr_en          = 1'b1;
				store_req.wr_addr        = slot_q;
				store_req.wr_data.page   = page_q;
				store_req.wr_data.frame  = frame_q;
				store_req.wr_data.access = acc_q;
				state_d = (r_valid && r_writable) ? ST_MAP_WB : ST_DONE;
			end

			ST_MAP_WB: begin
				push_valid      = 1'b1;
				push_res.kind   = smtlb_pkg::KIND_WRITEBACK;
				push_res.slot   = slot_q;
				push_res.page   = rdata.page;
				push_res.frame  = rdata.frame;
				push_res.access = rdata.access;
				if (push_ready) begin
					state_d = ST_DONE;
				end
			end

			ST_WALK: begin
				if (cmd_q == smtlb_pkg::CMD_PROBE) begin
					if (r_valid && r_match) begin
						push_valid      = 1'b1;
						push_res.kind   = smtlb_pkg::KIND_PROBE;
						push_res.hit    = 1'b1;
						push_res.slot   = smtlb_pkg::SLOT_W'(idx_q);
						push_res.page   = rdata.page;
						push_res.frame  = rdata.frame;
						push_res.access = rdata.access;
						push_res.last   = 1'b1;
						if (push_ready) begin
							state_d = ST_IDLE;
						end
					end else if (idx_last) begin
						push_valid    = 1'b1;
						push_res.kind = smtlb_pkg::KIND_PROBE;
						push_res.last = 1'b1;
						if (push_ready) begin
							state_d = ST_IDLE;
						end
					end else begin
						store_req.rd_en   = 1'b1;
						store_req.rd_addr = smtlb_pkg::SLOT_W'(idx_q + 1'b1);
						idx_d = idx_q + 1'b1;
					end
				end else if (!walk_wb || push_ready) begin
					push_valid      = walk_wb;
					push_res.kind   = smtlb_pkg::KIND_WRITEBACK;
					push_res.slot   = smtlb_pkg::SLOT_W'(idx_q);
					push_res.page   = rdata.page;
					push_res.frame  = rdata.frame;
					push_res.access = rdata.access;
					store_req.clr_en   = walk_clr;
					store_req.clr_addr = smtlb_pkg::SLOT_W'(idx_q);
					if (idx_last) begin
						state_d = ST_DONE;
					end else begin
						store_req.rd_en   = 1'b1;
						store_req.rd_addr = smtlb_pkg::SLOT_W'(idx_q + 1'b1);
						idx_d = idx_q + 1'b1;
					end
				end
			end

			ST_DONE: begin
				push_valid    = 1'b1;
				push_res.kind = smtlb_pkg::KIND_DONE;
				push_res.last = 1'b1;
				if (push_ready) begin
					state_d = ST_IDLE;
				end
			end

			ST_ERR: begin
				push_valid    = 1'b1;
				push_res.kind = smtlb_pkg::KIND_BAD_INDEX;
				push_res.slot = slot_q;
				push_res.last = 1'b1;
				if (push_ready) begin
					state_d = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			cmd_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (in_valid && in_ready) begin
				cmd_q <= in_cmd;
			end
		end
	end

	// command operands
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			slot_q  <= in_slot;
			page_q  <= in_page;
			frame_q <= in_frame;
			acc_q   <= in_access;
		end
	end

endmodule

`default_nettype wire

// ===== src/smtlb_obuf.sv =====
// ----------------------------------------------------------------------------
// smtlb_obuf
// output register: holds one result word until the downstream side takes it
// ----------------------------------------------------------------------------
`default_nettype none

module smtlb_obuf (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push_valid,
	output logic                 push_ready,
	input  smtlb_pkg::result_t   push_res,
	output logic                 out_valid,
	input  wire                  out_ready,
	output smtlb_pkg::result_t   out_res
);

	logic               valid_q;
	smtlb_pkg::result_t res_q;

	assign push_ready = !valid_q || out_ready;
	assign out_valid  = valid_q;
	assign out_res    = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push_ready) begin
			valid_q <= push_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (push_valid && push_ready) begin
			res_q <= push_res;
		end
	end

endmodule

`default_nettype wire

// ===== tb/software_managed_tlb_checker.sv =====
// ----------------------------------------------------------------------------
// software_managed_tlb_checker
// watches both streams of the translation buffer, keeps its own copy of the
// slots, predicts every result word and compares it field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module software_managed_tlb_checker #(
	parameter int ENTRIES = smtlb_pkg::ENTRIES_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_axis_tvalid,
	input  wire        s_axis_tready,
	// slot[5:0], page[37:6], frame_addr[85:38], access[88:86], zero pad
	input  wire [95:0] s_axis_tdata,
	// cmd[2:0]
	input  wire [2:0]  s_axis_tuser,
	input  wire        m_axis_tvalid,
	input  wire        m_axis_tready,
	// hit[0], slot_out[6:1], page_out[38:7], frame_out[86:39],
	// access_out[89:87], zero pad
	input  wire [95:0] m_axis_tdata,
	// kind[2:0]
	input  wire [2:0]  m_axis_tuser,
	input  wire        m_axis_tlast,
	output int         fail_count,
	output int         outstanding,
	output int         words_checked,
	output int         writebacks_checked
);

	import smtlb_pkg::*;

	localparam int REPORT_LIMIT = 10;

	// shadow of the slot store
	logic [PAGE_W-1:0]  slot_page   [ENTRIES];
	logic [FRAME_W-1:0] slot_frame  [ENTRIES];
	logic [ACC_W-1:0]   slot_access [ENTRIES];

	result_t expected_words[$];
	int      failures  = 0;
	int      checked   = 0;
	int      writebacks = 0;

	function automatic result_t make_word(input logic [KIND_W-1:0] kind, input logic hit,
			input logic [SLOT_W-1:0] slot, input logic [PAGE_W-1:0] page,
			input logic [FRAME_W-1:0] frame, input logic [ACC_W-1:0] access,
			input logic last);
		result_t w;
		w.kind = kind;
		w.hit = hit;
		w.slot = slot;
		w.page = page;
		w.frame = frame;
		w.access = access;
		w.last = last;
		return w;
	endfunction

	// dirty-capable valid slots are reported; map, unmap and flush then clear them
	task automatic queue_writeback(input int i);
		if (slot_frame[i] != '0 && slot_access[i][ACC_WRITE_BIT])
			expected_words.push_back(make_word(KIND_WRITEBACK, 1'b0, SLOT_W'(i),
				slot_page[i], slot_frame[i], slot_access[i], 1'b0));
	endtask

	task automatic clear_entry(input int i);
		slot_page[i] = '0;
		slot_frame[i] = '0;
		slot_access[i] = '0;
	endtask

	task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
			input logic [PAGE_W-1:0] page, input logic [FRAME_W-1:0] frame,
			input logic [ACC_W-1:0] access);
		logic found;
		logic ends_done;
		found = 1'b0;
		ends_done = 1'b1;
		case (cmd)
			CMD_MAP: begin
				if (int'(slot) >= ENTRIES) begin
					expected_words.push_back(make_word(KIND_BAD_INDEX, 1'b0, slot,
						'0, '0, '0, 1'b1));
					ends_done = 1'b0;
				end else begin
					if (slot_frame[slot] != '0) begin
						queue_writeback(int'(slot));
						clear_entry(int'(slot));
					end
					slot_page[slot] = page;
					slot_frame[slot] = frame;
					slot_access[slot] = access;
				end
			end
			CMD_READ: begin
				ends_done = 1'b0;
				if (int'(slot) >= ENTRIES)
					expected_words.push_back(make_word(KIND_BAD_INDEX, 1'b0, slot,
						'0, '0, '0, 1'b1));
				else
					expected_words.push_back(make_word(KIND_SLOT, 1'b0, slot,
						slot_page[slot], slot_frame[slot], slot_access[slot], 1'b1));
			end
			CMD_PROBE: begin
				ends_done = 1'b0;
				// lowest valid matching slot wins
				for (int i = 0; i < ENTRIES; i++) begin
					if (!found && slot_frame[i] != '0 && slot_page[i] == page) begin
						expected_words.push_back(make_word(KIND_PROBE, 1'b1, SLOT_W'(i),
							slot_page[i], slot_frame[i], slot_access[i], 1'b1));
						found = 1'b1;
					end
				end
				if (!found)
					expected_words.push_back(make_word(KIND_PROBE, 1'b0, '0, '0, '0, '0,
						1'b1));
			end
			CMD_UNMAP: begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (slot_frame[i] != '0 && slot_page[i] == page) begin
						queue_writeback(i);
						clear_entry(i);
					end
				end
			end
			CMD_FLUSH: begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (slot_frame[i] != '0) begin
						queue_writeback(i);
						clear_entry(i);
					end
				end
			end
			CMD_SYNC: begin
				for (int i = 0; i < ENTRIES; i++)
					queue_writeback(i);
			end
			default: begin
				// spare codes leave the store alone
			end
		endcase
		if (ends_done)
			expected_words.push_back(make_word(KIND_DONE, 1'b0, '0, '0, '0, '0, 1'b1));
	endtask

	task automatic report(input string what, input result_t want, input result_t got);
		if (failures < REPORT_LIMIT) begin
			$display("%0t %s", $time, what);
			$display("  expected kind %0d hit %0b slot %0d page %h frame %h acc %0d last %0b",
				want.kind, want.hit, want.slot, want.page, want.frame,
				want.access, want.last);
			$display("  got      kind %0d hit %0b slot %0d page %h frame %h acc %0d last %0b",
				got.kind, got.hit, got.slot, got.page, got.frame,
				got.access, got.last);
		end
		failures++;
	endtask

	task automatic check_word(input result_t got);
		result_t want;
		logic    bad;
		if (expected_words.size() == 0) begin
			report("unexpected result word", '0, got);
		end else begin
			want = expected_words.pop_front();
			bad = (got.kind !== want.kind) || (got.hit !== want.hit)
				|| (got.slot !== want.slot) || (got.page !== want.page)
				|| (got.frame !== want.frame) || (got.access !== want.access)
				|| (got.last !== want.last);
			if (bad)
				report("result mismatch", want, got);
			if (want.kind == KIND_WRITEBACK)
				writebacks++;
		end
		checked++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++)
				clear_entry(i);
			expected_words.delete();
		end else begin
			// the finishing word of one command and the next command can share an edge;
			// the older expectation is at the front either way
			if (m_axis_tvalid && m_axis_tready) begin
				got.kind = m_axis_tuser;
				got.hit = m_axis_tdata[0];
				got.slot = m_axis_tdata[6:1];
				got.page = m_axis_tdata[38:7];
				got.frame = m_axis_tdata[86:39];
				got.access = m_axis_tdata[89:87];
				got.last = m_axis_tlast;
				check_word(got);
			end
			if (s_axis_tvalid && s_axis_tready)
				apply_command(s_axis_tuser, s_axis_tdata[5:0], s_axis_tdata[37:6],
					s_axis_tdata[85:38], s_axis_tdata[88:86]);
		end
		fail_count <= failures;
		outstanding <= expected_words.size();
		words_checked <= checked;
		writebacks_checked <= writebacks;
	end

endmodule

// ===== tb/software_managed_tlb_tb.sv =====
// ----------------------------------------------------------------------------
// software_managed_tlb_tb
// drives commands into the translation buffer with random idle bursts on
// both streams; a checker beside the block predicts and compares results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module software_managed_tlb_tb;

	import smtlb_pkg::*;

	localparam int ENTRIES      = ENTRIES_DEF;
	localparam int RESET_CYCLES = 6;
	localparam int RANDOM_ITEMS = 470;
	// last stretch of the run goes without any idling
	localparam int QUIET_ITEMS  = 60;
	// a walk over all slots plus margin
	localparam int DRAIN_CYCLES = 2 * ENTRIES + 16;
	localparam int CYCLE_LIMIT  = 1000000;

	// codes the block treats as no-ops
	localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [95:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;

	int fail_count;
	int outstanding;
	int words_checked;
	int writebacks_checked;

	// idling control: calm switches idling off for stretches, final_phase for good
	logic calm = 1'b0;
	logic final_phase = 1'b0;
	int   stall_left = 0;
	int   cycle_count = 0;
	int   words_sent = 0;
	logic [PAGE_W-1:0] page_pool [8];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	software_managed_tlb #(
		.ENTRIES(ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	software_managed_tlb_checker #(
		.ENTRIES(ENTRIES)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.fail_count(fail_count),
		.outstanding(outstanding),
		.words_checked(words_checked),
		.writebacks_checked(writebacks_checked)
	);

	// result side back-pressure in random stall bursts
	always @(negedge clk) begin
		if (calm || final_phase) begin
			m_axis_tready <= 1'b1;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 7) == 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= $urandom_range(0, 15);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("software_managed_tlb_tb failed");
			$finish;
		end
	end

	// one command word, with an optional idle burst ahead of it
	task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
			input logic [PAGE_W-1:0] page, input logic [FRAME_W-1:0] frame,
			input logic [ACC_W-1:0] access);
		int gap;
		gap = 0;
		if (!calm && !final_phase && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 16);
		if (gap != 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'd0, access, frame, page, slot};
		s_axis_tuser <= cmd;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		words_sent++;
	endtask

	// pages mostly from a small pool so probes and unmaps find matches
	function automatic logic [PAGE_W-1:0] pick_page();
		if ($urandom_range(0, 3) != 0)
			return page_pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	function automatic logic [FRAME_W-1:0] pick_frame(input logic allow_empty);
		logic [63:0] wide;
		int          sel;
		wide = {$urandom, $urandom};
		sel = $urandom_range(0, 99);
		if (allow_empty && sel < 8)
			return '0;
		if (sel >= 95)
			return '1;
		if (wide[FRAME_W-1:0] == '0)
			return FRAME_W'(1);
		return wide[FRAME_W-1:0];
	endfunction

	task automatic send_random_command();
		int                 sel;
		logic [CMD_W-1:0]   cmd;
		logic [SLOT_W-1:0]  slot;
		logic [63:0]        wide;
		sel = $urandom_range(0, 99);
		if (int'(sel) >= 94) begin
			// noise: every field fully random
			wide = {$urandom, $urandom};
			send_word(CMD_W'($urandom_range(0, 7)), SLOT_W'($urandom_range(0, 63)),
				$urandom, wide[FRAME_W-1:0], ACC_W'($urandom_range(0, 7)));
		end else begin
			if (sel < 30)      cmd = CMD_MAP;
			else if (sel < 42) cmd = CMD_READ;
			else if (sel < 62) cmd = CMD_PROBE;
			else if (sel < 74) cmd = CMD_UNMAP;
			else if (sel < 80) cmd = CMD_FLUSH;
			else if (sel < 89) cmd = CMD_SYNC;
			else if (sel < 91) cmd = CMD_SPARE_6;
			else               cmd = CMD_SPARE_7;
			// out-of-range index now and then
			if ($urandom_range(0, 99) < 12)
				slot = SLOT_W'($urandom_range(ENTRIES, 63));
			else
				slot = SLOT_W'($urandom_range(0, ENTRIES - 1));
			send_word(cmd, slot, pick_page(), pick_frame(1'b1),
				ACC_W'($urandom_range(0, 7)));
		end
	endtask

	// fill every slot, then flush or sync: the longest result bursts
	task automatic fill_and_drain();
		logic [ACC_W-1:0] access;
		for (int i = 0; i < ENTRIES; i++) begin
			access = ACC_W'($urandom_range(0, 7));
			if ($urandom_range(0, 9) < 7)
				access[ACC_WRITE_BIT] = 1'b1;
			send_word(CMD_MAP, SLOT_W'(i), pick_page(), pick_frame(1'b0), access);
		end
		send_word($urandom_range(0, 1) ? CMD_FLUSH : CMD_SYNC, '0, '0, '0, '0);
	endtask

	initial begin
		int first_random;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// directed part
		// empty store: read of slot zero gives zeros, probe of page zero must miss
		send_word(CMD_READ, '0, '0, '0, '0);
		send_word(CMD_PROBE, '0, '0, '0, '0);
		send_word(CMD_FLUSH, '0, '0, '0, '0);
		// extremes of every field, first and last slot
		send_word(CMD_MAP, '0, '1, '1, 3'd7);
		send_word(CMD_MAP, SLOT_W'(ENTRIES - 1), '0, FRAME_W'(1), 3'd2);
		// bad index on map and read
		send_word(CMD_MAP, SLOT_W'(ENTRIES), 32'h1234_5678, FRAME_W'(48'h55), 3'd7);
		send_word(CMD_READ, '1, '0, '0, '0);
		send_word(CMD_MAP, '1, '1, '1, 3'd7);
		send_word(CMD_READ, '0, '0, '0, '0);
		send_word(CMD_PROBE, '0, '1, '0, '0);
		send_word(CMD_PROBE, '0, '0, '0, '0);
		// duplicate page: probe reports the lowest slot
		send_word(CMD_MAP, SLOT_W'(3), '1, FRAME_W'(5), 3'd3);
		send_word(CMD_PROBE, '0, '1, '0, '0);
		// unmap clears both copies, both write back
		send_word(CMD_UNMAP, '0, '1, '0, '0);
		send_word(CMD_MAP, SLOT_W'(5), 32'hA5A5_A5A5, FRAME_W'(48'h10), 3'd2);
		send_word(CMD_MAP, SLOT_W'(6), 32'hA5A5_A5A5, FRAME_W'(48'h20), 3'd1);
		// zero frame leaves the slot empty although the page matches
		send_word(CMD_MAP, SLOT_W'(7), 32'hA5A5_A5A5, '0, 3'd7);
		// overwrite of a writable slot writes the old contents back
		send_word(CMD_MAP, SLOT_W'(5), 32'h5A5A_5A5A, FRAME_W'(48'h8000_0000_0000), 3'd6);
		// read-only match clears silently
		send_word(CMD_UNMAP, '0, 32'hA5A5_A5A5, '0, '0);
		send_word(CMD_SYNC, '0, '0, '0, '0);
		send_word(CMD_SPARE_6, '1, '1, '1, 3'd7);
		send_word(CMD_SPARE_7, '0, '0, '0, '0);
		send_word(CMD_FLUSH, '0, '0, '0, '0);
		send_word(CMD_READ, SLOT_W'(5), '0, '0, '0);

		// random part
		for (int k = 0; k < 8; k++)
			page_pool[k] = $urandom;
		page_pool[0] = '0;
		page_pool[1] = '1;
		first_random = words_sent;
		while (words_sent - first_random < RANDOM_ITEMS) begin
			if (words_sent - first_random >= RANDOM_ITEMS - QUIET_ITEMS)
				final_phase <= 1'b1;
			else if ($urandom_range(0, 29) == 0)
				calm <= ~calm;
			if ($urandom_range(0, 49) == 0)
				page_pool[$urandom_range(2, 7)] = $urandom;
			if ($urandom_range(0, 14) == 0
					&& words_sent - first_random + ENTRIES + 1 <= RANDOM_ITEMS)
				fill_and_drain();
			else
				send_random_command();
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		// let every expected word arrive, then watch for strays
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("sent %0d commands (map, read, probe, unmap, flush, sync,", words_sent);
		$display("spare codes, bad indexes) under random stalls on both sides");
		$display("checked %0d result words, %0d of them write-back requests",
			words_checked, writebacks_checked);
		if (fail_count == 0 && outstanding == 0)
			$display("software_managed_tlb_tb passed");
		else
			$display("software_managed_tlb_tb failed");
		$finish;
	end

endmodule

// ===== software_managed_tlb.f =====
src/smtlb_pkg.sv
src/smtlb_store.sv
src/smtlb_ctrl.sv
src/smtlb_obuf.sv
src/software_managed_tlb.sv
tb/software_managed_tlb_checker.sv
tb/software_managed_tlb_tb.sv
